FILE: sv/qte_pkg.sv
// Package for the quaternion to Euler angle converter.
// Holds widths, constants and the arctangent table; depends on nothing.
`timescale 1ns / 1ps

package qte_pkg;

    localparam int COMPONENT_WIDTH = 16;
    localparam int CORDIC_STAGES   = 16;
    localparam int TABLE_LEN       = 24;
    localparam int NST = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

    localparam int PROD_SHIFT = ((2 * COMPONENT_WIDTH - 2) > 29) ?
                                (2 * COMPONENT_WIDTH - 31) : 0;
    localparam int PW  = 2 * COMPONENT_WIDTH - PROD_SHIFT;
    localparam int SW  = PW + 3;
    localparam int CXW = SW + 3;
    localparam int RW  = 2 * SW;
    localparam int SQ  = RW / 2;
    localparam int AW  = 34;
    localparam int MW  = AW + 32;
    localparam int QW  = MW - 47;

    localparam logic signed [AW-1:0] PI_BAM = AW'(64'sd2147483648);
    localparam logic signed [31:0] PI_Q29 = 32'sd1686629713;
    localparam int ANGLE_LIMIT = 25736;
    localparam int HALF_PI_OUT = 12868;

    localparam logic [31:0] ATAN_BAM [TABLE_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331, 32'd21354465, 32'd10679822, 32'd5340245,
        32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
        32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304,
        32'd652, 32'd326, 32'd163, 32'd81
    };

    typedef struct packed {
        logic zero;
        logic clamp;
        logic s_pos;
        logic s_neg;
    } qte_flags_t;

endpackage

FILE: sv/quaternion_to_euler_core.sv
// Top level of the quaternion to Euler angle converter.
// Depends on qte_pkg, qte_isqrt, qte_cordic and qte_angle.
`timescale 1ns / 1ps

// Usage:
// A request on the input channel carries one quaternion (quat_w, quat_x, quat_y,
// quat_z) in signed Q1.14. It is taken at a rising edge where in_valid is high
// and in_stall is low. The output channel gives roll and yaw in signed Q2.13
// radians, pitch in signed Q1.13 radians and zero_quaternion, taken where
// out_valid is high and out_stall is low.
// The pipeline accepts one request per cycle while in_stall is low. Its
// registers hold, in order, the products, the sums, the root operands, the
// radicand, each bit of the square root, the CORDIC pre-rotation and each
// CORDIC stage, the angle multiply and the saturated output register.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits; the pipeline is empty afterwards and data
// registers hold no meaning until refilled.

module quaternion_to_euler_core
    import qte_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] quat_w,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] roll_angle,
    output logic signed [14:0] pitch_angle,
    output logic signed [15:0] yaw_angle,
    output logic               zero_quaternion
);

    localparam int CW  = COMPONENT_WIDTH;
    localparam int LAT = 4 + SQ + NST + 3;
    localparam int DLY = 2 + SQ;
    localparam int FLN = LAT - 3;

    function automatic logic signed [CW-1:0] take(input logic [15:0] p);
        logic [CW+15:0] e;
        e = {{CW{1'b0}}, p};
        return e[CW-1:0];
    endfunction

    function automatic logic signed [PW-1:0] prd(input logic signed [CW-1:0] a,
                                                 input logic signed [CW-1:0] b);
        logic signed [2*CW-1:0] m;
        m = a * b;
        return PW'(m >>> PROD_SHIFT);
    endfunction

    logic adv;
    logic [LAT-1:0] vld_reg;

    assign adv      = !(vld_reg[LAT-1] && out_stall);
    assign in_stall = !adv;
    assign out_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    logic signed [CW-1:0] cw, cx, cy, cz;
    assign cw = take(quat_w);
    assign cx = take(quat_x);
    assign cy = take(quat_y);
    assign cz = take(quat_z);

    // Stage 1: products.
    logic signed [PW-1:0] ww_reg, xx_reg, yy_reg, zz_reg, wx_reg, yz_reg;
    logic signed [PW-1:0] wz_reg, xy_reg, wy_reg, zx_reg;
    logic zq1_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ww_reg  <= prd(cw, cw);
            xx_reg  <= prd(cx, cx);
            yy_reg  <= prd(cy, cy);
            zz_reg  <= prd(cz, cz);
            wx_reg  <= prd(cw, cx);
            yz_reg  <= prd(cy, cz);
            wz_reg  <= prd(cw, cz);
            xy_reg  <= prd(cx, cy);
            wy_reg  <= prd(cw, cy);
            zx_reg  <= prd(cz, cx);
            zq1_reg <= (cw == '0) && (cx == '0) && (cy == '0) && (cz == '0);
        end
    end

    // Stage 2: sums.
    logic signed [SW-1:0] n_reg, rs_reg, rc_reg, ys_reg, yc_reg, s_reg;
    logic zq2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n_reg   <= SW'(ww_reg) + SW'(xx_reg) + SW'(yy_reg) + SW'(zz_reg);
            rs_reg  <= (SW'(wx_reg) + SW'(yz_reg)) <<< 1;
            rc_reg  <= SW'(ww_reg) - SW'(xx_reg) - SW'(yy_reg) + SW'(zz_reg);
            ys_reg  <= (SW'(wz_reg) + SW'(xy_reg)) <<< 1;
            yc_reg  <= SW'(ww_reg) + SW'(xx_reg) - SW'(yy_reg) - SW'(zz_reg);
            s_reg   <= (SW'(wy_reg) - SW'(zx_reg)) <<< 1;
            zq2_reg <= zq1_reg;
        end
    end

    // Stage 3: range check and root operands; stage 4: radicand.
    logic [SW-1:0] nms_reg, nps_reg;
    logic [RW-1:0] rad_reg;
    qte_flags_t    fl_reg [FLN];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nms_reg         <= $unsigned(n_reg - s_reg);
            nps_reg         <= $unsigned(n_reg + s_reg);
            fl_reg[0].zero  <= zq2_reg;
            fl_reg[0].clamp <= (s_reg >= n_reg) || (-s_reg >= n_reg);
            fl_reg[0].s_pos <= s_reg > 0;
            fl_reg[0].s_neg <= s_reg < 0;
            rad_reg         <= RW'(nms_reg) * RW'(nps_reg);
            for (int k = 1; k < FLN; k++)
            begin
                fl_reg[k] <= fl_reg[k-1];
            end
        end
    end

    logic signed [SW-1:0] rs_dl_reg [DLY];
    logic signed [SW-1:0] rc_dl_reg [DLY];
    logic signed [SW-1:0] ys_dl_reg [DLY];
    logic signed [SW-1:0] yc_dl_reg [DLY];
    logic signed [SW-1:0] s_dl_reg  [DLY];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rs_dl_reg[0] <= rs_reg;
            rc_dl_reg[0] <= rc_reg;
            ys_dl_reg[0] <= ys_reg;
            yc_dl_reg[0] <= yc_reg;
            s_dl_reg[0]  <= s_reg;
            for (int k = 1; k < DLY; k++)
            begin
                rs_dl_reg[k] <= rs_dl_reg[k-1];
                rc_dl_reg[k] <= rc_dl_reg[k-1];
                ys_dl_reg[k] <= ys_dl_reg[k-1];
                yc_dl_reg[k] <= yc_dl_reg[k-1];
                s_dl_reg[k]  <= s_dl_reg[k-1];
            end
        end
    end

    logic [SW-1:0] root;

    qte_isqrt u_isqrt (
        .clk  (clk),
        .en   (adv),
        .rad  (rad_reg),
        .root (root)
    );

    logic signed [AW-1:0] roll_bam, pitch_bam, yaw_bam;
    logic signed [QW-1:0] roll_q, pitch_q, yaw_q;

    qte_cordic u_cordic_roll (
        .clk   (clk),
        .en    (adv),
        .y_in  (CXW'(rs_dl_reg[DLY-1])),
        .x_in  (CXW'(rc_dl_reg[DLY-1])),
        .angle (roll_bam)
    );

    qte_cordic u_cordic_pitch (
        .clk   (clk),
        .en    (adv),
        .y_in  (CXW'(s_dl_reg[DLY-1])),
        .x_in  ($signed(CXW'(root))),
        .angle (pitch_bam)
    );

    qte_cordic u_cordic_yaw (
        .clk   (clk),
        .en    (adv),
        .y_in  (CXW'(ys_dl_reg[DLY-1])),
        .x_in  (CXW'(yc_dl_reg[DLY-1])),
        .angle (yaw_bam)
    );

    qte_angle u_angle_roll  (.clk(clk), .en(adv), .bam(roll_bam),  .q(roll_q));
    qte_angle u_angle_pitch (.clk(clk), .en(adv), .bam(pitch_bam), .q(pitch_q));
    qte_angle u_angle_yaw   (.clk(clk), .en(adv), .bam(yaw_bam),   .q(yaw_q));

    localparam logic signed [QW-1:0] LIM_A = QW'(ANGLE_LIMIT);
    localparam logic signed [QW-1:0] LIM_P = QW'(HALF_PI_OUT);

    qte_flags_t fl_out;
    logic signed [QW-1:0] roll_s, pitch_s, yaw_s;
    logic signed [15:0] roll_next, yaw_next;
    logic signed [14:0] pitch_next;

    assign fl_out = fl_reg[FLN-1];

    always_comb
    begin
        roll_s  = (roll_q > LIM_A) ? LIM_A : ((roll_q < -LIM_A) ? -LIM_A : roll_q);
        yaw_s   = (yaw_q > LIM_A) ? LIM_A : ((yaw_q < -LIM_A) ? -LIM_A : yaw_q);
        pitch_s = (pitch_q > LIM_P) ? LIM_P : ((pitch_q < -LIM_P) ? -LIM_P : pitch_q);
        priority if (fl_out.zero)
        begin
            roll_next  = '0;
            yaw_next   = '0;
            pitch_next = '0;
        end
        else if (fl_out.clamp)
        begin
            roll_next  = 16'(roll_s);
            yaw_next   = 16'(yaw_s);
            pitch_next = fl_out.s_pos ? 15'(LIM_P) :
                         (fl_out.s_neg ? 15'(-LIM_P) : '0);
        end
        else
        begin
            roll_next  = 16'(roll_s);
            yaw_next   = 16'(yaw_s);
            pitch_next = 15'(pitch_s);
        end
    end

    logic signed [15:0] roll_reg, yaw_reg;
    logic signed [14:0] pitch_reg;
    logic zero_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            roll_reg  <= roll_next;
            pitch_reg <= pitch_next;
            yaw_reg   <= yaw_next;
            zero_reg  <= fl_out.zero;
        end
    end

    assign roll_angle      = roll_reg;
    assign pitch_angle     = pitch_reg;
    assign yaw_angle       = yaw_reg;
    assign zero_quaternion = zero_reg;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall does not follow a blocked output");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> vld_reg[0])
        else $error("accepted request did not enter the pipeline");

    a_zero_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && zero_quaternion) |->
        (roll_angle == '0 && pitch_angle == '0 && yaw_angle == '0))
        else $error("zero quaternion with nonzero angles");

    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pitch_angle <= 15'sd12868 && pitch_angle >= -15'sd12868))
        else $error("pitch outside half pi");

endmodule

FILE: sv/qte_isqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on qte_pkg.
`timescale 1ns / 1ps

module qte_isqrt
    import qte_pkg::*;
(
    input  logic          clk,
    input  logic          en,
    input  logic [RW-1:0] rad,
    output logic [SW-1:0] root
);

    logic [RW:0] v_reg [SQ];
    logic [RW:0] r_reg [SQ];

    genvar k;
    generate
        for (k = 0; k < SQ; k++) begin : g_stage
            logic [RW:0] v_in, r_in, v_next, r_next, bitv, trial;
            if (k == 0) begin : g_first
                assign v_in = {1'b0, rad};
                assign r_in = '0;
            end else begin : g_rest
                assign v_in = v_reg[k-1];
                assign r_in = r_reg[k-1];
            end
            assign bitv  = (RW + 1)'(1) << (RW - 2 - 2 * k);
            assign trial = r_in + bitv;
            always_comb
            begin
                if (v_in >= trial)
                begin
                    v_next = v_in - trial;
                    r_next = (r_in >> 1) + bitv;
                end
                else
                begin
                    v_next = v_in;
                    r_next = r_in >> 1;
                end
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    v_reg[k] <= v_next;
                    r_reg[k] <= r_next;
                end
            end
        end
    endgenerate

    assign root = r_reg[SQ-1][SW-1:0];

endmodule

FILE: sv/qte_cordic.sv
// Pipelined vectoring CORDIC giving a binary angle for atan2(y, x).
// Depends on qte_pkg.
`timescale 1ns / 1ps

module qte_cordic
    import qte_pkg::*;
(
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [CXW-1:0] y_in,
    input  logic signed [CXW-1:0] x_in,
    output logic signed [AW-1:0]  angle
);

    logic signed [CXW-1:0] x_reg [NST+1];
    logic signed [CXW-1:0] y_reg [NST+1];
    logic signed [AW-1:0]  z_reg [NST+1];
    logic                  nul_reg [NST+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nul_reg[0] <= (x_in == '0) && (y_in == '0);
            if (x_in < 0)
            begin
                x_reg[0] <= -x_in;
                y_reg[0] <= -y_in;
                z_reg[0] <= (y_in >= 0) ? PI_BAM : -PI_BAM;
            end
            else
            begin
                x_reg[0] <= x_in;
                y_reg[0] <= y_in;
                z_reg[0] <= '0;
            end
        end
    end

    genvar i;
    generate
        for (i = 0; i < NST; i++) begin : g_stage
            logic signed [CXW-1:0] dx, dy;
            logic signed [AW-1:0]  da;
            assign dx = x_reg[i] >>> i;
            assign dy = y_reg[i] >>> i;
            assign da = $signed({{(AW - 32){1'b0}}, ATAN_BAM[i]});
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    nul_reg[i+1] <= nul_reg[i];
                    if (y_reg[i] >= 0)
                    begin
                        x_reg[i+1] <= x_reg[i] + dy;
                        y_reg[i+1] <= y_reg[i] - dx;
                        z_reg[i+1] <= z_reg[i] + da;
                    end
                    else
                    begin
                        x_reg[i+1] <= x_reg[i] - dy;
                        y_reg[i+1] <= y_reg[i] + dx;
                        z_reg[i+1] <= z_reg[i] - da;
                    end
                end
            end
        end
    endgenerate

    assign angle = nul_reg[NST] ? '0 : z_reg[NST];

endmodule

FILE: sv/qte_angle.sv
// Converts a binary angle to Q5.13 radians with one registered multiply.
// Depends on qte_pkg.
`timescale 1ns / 1ps

module qte_angle
    import qte_pkg::*;
(
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [AW-1:0] bam,
    output logic signed [QW-1:0] q
);

    logic signed [MW-1:0] prod_reg;
    logic signed [MW-1:0] rounded;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= MW'(bam) * MW'(PI_Q29);
        end
    end

    assign rounded = prod_reg + (MW'(1) <<< 46);
    assign q = QW'(rounded >>> 47);

endmodule

FILE: tb/qte_checker.sv
// Checker for the quaternion to Euler angle converter: watches both channels,
// predicts each result in fixed point and compares it field by field.
// Depends on qte_pkg for the component width, stage count and arctangent table.
`timescale 1ns / 1ps

module qte_checker
    import qte_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [15:0] quat_w,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [15:0] roll_angle,
    input  logic signed [14:0] pitch_angle,
    input  logic signed [15:0] yaw_angle,
    input  logic               zero_quaternion,
    output int                 fail_count,
    output int                 pending
);

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic signed [15:0] yaw;
        logic               zero;
    } euler_t;

    euler_t angles_due[$];

    assign pending = angles_due.size();

    function automatic longint sign_ext(logic [15:0] v);
        logic [COMPONENT_WIDTH-1:0] low;
        low = v[COMPONENT_WIDTH-1:0];
        return longint'(signed'(low));
    endfunction

    function automatic longint scaled_product(longint a, longint b);
        return (a * b) >>> PROD_SHIFT;
    endfunction

    function automatic longint int_root(longint v);
        longint root;
        longint bit_w;
        root = 0;
        bit_w = 64'sd1 <<< 62;
        while (bit_w > v)
            bit_w = bit_w >>> 2;
        while (bit_w != 0)
        begin
            if (v >= root + bit_w)
            begin
                v = v - (root + bit_w);
                root = (root >>> 1) + bit_w;
            end
            else
                root = root >>> 1;
            bit_w = bit_w >>> 2;
        end
        return root;
    endfunction

    function automatic longint vector_angle(longint ys, longint xc);
        longint acc;
        longint dx;
        longint dy;
        acc = 0;
        if (xc == 0 && ys == 0)
            return 0;
        if (xc < 0)
        begin
            acc = (ys >= 0) ? 64'sd2147483648 : -64'sd2147483648;
            xc = -xc;
            ys = -ys;
        end
        for (int i = 0; i < NST; i++)
        begin
            dx = xc >>> i;
            dy = ys >>> i;
            if (ys >= 0)
            begin
                xc = xc + dy;
                ys = ys - dx;
                acc = acc + longint'(ATAN_BAM[i]);
            end
            else
            begin
                xc = xc - dy;
                ys = ys + dx;
                acc = acc - longint'(ATAN_BAM[i]);
            end
        end
        return acc;
    endfunction

    function automatic longint to_radians(longint bam, longint limit);
        longint r;
        r = (bam * 64'sd1686629713 + (64'sd1 <<< 46)) >>> 47;
        if (r > limit)
            r = limit;
        if (r < -limit)
            r = -limit;
        return r;
    endfunction

    function automatic euler_t predict_angles(logic [15:0] qw, logic [15:0] qx,
                                              logic [15:0] qy, logic [15:0] qz);
        longint w, x, y, z, xx, yy, zz, n, s, roll, pitch, yaw;
        euler_t e;
        w = sign_ext(qw);
        x = sign_ext(qx);
        y = sign_ext(qy);
        z = sign_ext(qz);
        roll = 0;
        pitch = 0;
        yaw = 0;
        e.zero = (w == 0 && x == 0 && y == 0 && z == 0);
        if (!e.zero)
        begin
            xx = scaled_product(x, x);
            yy = scaled_product(y, y);
            zz = scaled_product(z, z);
            n = scaled_product(w, w) + xx + yy + zz;
            roll = to_radians(vector_angle(
                2 * (scaled_product(w, x) + scaled_product(y, z)),
                n - 2 * (xx + yy)), ANGLE_LIMIT);
            yaw = to_radians(vector_angle(
                2 * (scaled_product(w, z) + scaled_product(x, y)),
                n - 2 * (yy + zz)), ANGLE_LIMIT);
            s = 2 * (scaled_product(w, y) - scaled_product(z, x));
            if (s >= n || -s >= n)
                pitch = (s > 0) ? HALF_PI_OUT : ((s < 0) ? -HALF_PI_OUT : 0);
            else
                pitch = to_radians(vector_angle(s, int_root((n - s) * (n + s))),
                                   HALF_PI_OUT);
        end
        e.roll = roll[15:0];
        e.pitch = pitch[14:0];
        e.yaw = yaw[15:0];
        return e;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        euler_t e;
        if (!rst_n)
        begin
            fail_count <= 0;
            angles_due.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
                angles_due.insert(angles_due.size(),
                                  predict_angles(quat_w, quat_x, quat_y, quat_z));
            if (out_valid && !out_stall)
            begin
                if (angles_due.size() == 0)
                begin
                    $error("result with no request outstanding");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = angles_due.pop_front();
                    if (roll_angle !== e.roll)
                        $error("roll_angle expected %0d actual %0d", e.roll, roll_angle);
                    if (pitch_angle !== e.pitch)
                        $error("pitch_angle expected %0d actual %0d", e.pitch, pitch_angle);
                    if (yaw_angle !== e.yaw)
                        $error("yaw_angle expected %0d actual %0d", e.yaw, yaw_angle);
                    if (zero_quaternion !== e.zero)
                        $error("zero_quaternion expected %0d actual %0d",
                               e.zero, zero_quaternion);
                    if (roll_angle !== e.roll || pitch_angle !== e.pitch ||
                        yaw_angle !== e.yaw || zero_quaternion !== e.zero)
                        fail_count <= fail_count + 1;
                end
            end
        end
    end

endmodule

FILE: tb/tb_quaternion_to_euler_core.sv
// Testbench top for quaternion_to_euler_core: drives directed and random
// quaternions with random gaps and stalls; qte_checker does the comparison.
`timescale 1ns / 1ps

module tb_quaternion_to_euler_core;

    localparam int RANDOM_REQUESTS = 700;
    localparam int CYCLE_LIMIT = 400000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic               out_valid;
    logic               out_stall;
    logic signed [15:0] roll_angle;
    logic signed [14:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic               zero_quaternion;
    int                 fail_count;
    int                 pending;
    int                 cycle_count;
    logic               sending_done;

    quaternion_to_euler_core i_dut (.*);

    qte_checker i_checker (.*);

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic int gap_length();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(5, 40);
    endfunction

    function automatic logic [15:0] random_component(int style);
        case (style)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 2) == 0 ? 16'sh8000 :
                          ($urandom_range(0, 1) ? 16'sh7FFF : 16'sh0000));
            2: return 16'($signed($urandom_range(0, 8)) - 4);
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    task automatic send_quaternion(logic [15:0] w, logic [15:0] x,
                                   logic [15:0] y, logic [15:0] z);
        int gap;
        gap = gap_length();
        if ($urandom_range(0, 2) == 0)
            gap = 0;
        repeat (gap)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        quat_w <= w;
        quat_x <= x;
        quat_y <= y;
        quat_z <= z;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    initial
    begin
        int style;
        rst_n = 1'b0;
        in_valid = 1'b0;
        quat_w = '0;
        quat_x = '0;
        quat_y = '0;
        quat_z = '0;
        sending_done = 1'b0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_quaternion(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_quaternion(16'h4000, 16'h0000, 16'h0000, 16'h0000);
        send_quaternion(16'h0000, 16'h4000, 16'h0000, 16'h0000);
        send_quaternion(16'h0000, 16'h0000, 16'h4000, 16'h0000);
        send_quaternion(16'h0000, 16'h0000, 16'h0000, 16'h4000);
        send_quaternion(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_quaternion(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_quaternion(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
        send_quaternion(16'h2D41, 16'h0000, 16'h2D41, 16'h0000);
        send_quaternion(16'h2D41, 16'h0000, 16'hD2BF, 16'h0000);
        send_quaternion(16'h0001, 16'h0000, 16'h0000, 16'h0000);
        send_quaternion(16'h0000, 16'h0001, 16'h0001, 16'h0000);
        send_quaternion(16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001);
        send_quaternion(16'h0000, 16'h4000, 16'h0000, 16'hC000);
        send_quaternion(16'h2000, 16'hE000, 16'h2000, 16'hE000);
        send_quaternion(16'h0000, 16'h0000, 16'h0001, 16'h0001);
        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            if (i == RANDOM_REQUESTS / 2)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
            style = $urandom_range(0, 9);
            style = (style < 4) ? 0 : ((style < 5) ? 1 : ((style < 6) ? 2 : 3));
            send_quaternion(random_component(style), random_component(style),
                            random_component(style), random_component(style));
        end
        in_valid <= 1'b0;
        sending_done <= 1'b1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if ($urandom_range(0, 99) < 3)
            out_stall <= 1'b1;
        else if ($urandom_range(0, 99) < 50)
            out_stall <= ($urandom_range(0, 3) == 0);
    end

    initial
    begin
        cycle_count = 0;
        @(posedge rst_n);
        while (!(sending_done && pending == 0) && cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
        begin
            repeat (80)
                @(posedge clk);
            if (fail_count == 0)
                $display("TB_OK");
            else
                $display("TB_ERROR");
            $finish;
        end
    end

endmodule

FILE: filelist.f
sv/qte_pkg.sv
sv/qte_isqrt.sv
sv/qte_cordic.sv
sv/qte_angle.sv
sv/quaternion_to_euler_core.sv
tb/qte_checker.sv
tb/tb_quaternion_to_euler_core.sv
